>>> src/bmp24_pixel_invert_grayscale_macros.svh
// assertion macros used by the bmp pixel rewriter checker
`ifndef BMP24_PIXEL_INVERT_GRAYSCALE_MACROS_SVH
`define BMP24_PIXEL_INVERT_GRAYSCALE_MACROS_SVH

// condition must hold in the same cycle
`define BPIG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bpig: same-cycle check failed");

// condition must hold in the following cycle
`define BPIG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bpig: next-cycle check failed");

// a stalled channel keeps valid and payload
`define BPIG_ASSERT_HOLD(lbl, vld, rdy, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) ((vld) && !(rdy)) |=> \
    ((vld) && $stable(sig))) else $error("bpig: stalled transfer changed");

`endif

>>> src/bpig_pkg.sv
// shared types and constants of the bmp pixel rewriter
package bpig_pkg;

  // what the back end does with a queued entry
  typedef enum logic [1:0] {
    OP_PASS,
    OP_INVERT,
    OP_GRAY
  } op_t;

  // one queued entry: up to three result bytes of one input byte
  typedef struct packed {
    op_t             op;
    logic [1:0]      count;
    logic [2:0][7:0] slots;
    logic            err;
    logic            last;
  } entry_t;

  // queue between front and back
  localparam int QUEUE_PTR_BITS = 2;
  localparam int QUEUE_DEPTH    = 1 << QUEUE_PTR_BITS;

  // header layout, positions of the final byte of each field
  localparam logic [31:0] POS_SIG_END    = 32'd1;
  localparam logic [31:0] POS_OFFSET_END = 32'd13;
  localparam logic [31:0] POS_DIB_END    = 32'd17;
  localparam logic [31:0] POS_WIDTH_END  = 32'd21;
  localparam logic [31:0] POS_HEIGHT_END = 32'd25;
  localparam logic [31:0] POS_DEPTH_END  = 32'd29;
  localparam logic [31:0] HEADER_LEN     = 32'd54;

  // header values accepted
  localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
  localparam logic [31:0] DIB_SIZE      = 32'd40;
  localparam logic [15:0] COLOUR_BITS   = 16'd24;

endpackage

>>> src/bpig_front.sv
// front end: header parser and byte classifier
module bpig_front
  import bpig_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_mode,
  input  logic       q_full,
  output logic       push_valid,
  output entry_t     push_entry
);

  typedef enum logic [1:0] {
    CH_BLUE,
    CH_GREEN,
    CH_RED
  } chan_t;

  logic        mode_r;
  logic [31:0] pos_r, pos_nxt;
  logic [31:0] field_r, field_nxt;
  logic [31:0] offset_r, offset_nxt;
  logic [31:0] width_r, width_nxt;
  logic [31:0] height_r, height_nxt;
  logic [31:0] col_r, col_nxt;
  logic [31:0] row_r, row_nxt;
  chan_t       chan_r, chan_nxt;
  logic [7:0]  held_b_r, held_b_nxt;
  logic [7:0]  held_g_r, held_g_nxt;
  logic [1:0]  pad_r, pad_nxt;
  logic        err_r, err_nxt;

  logic            take;
  logic [31:0]     asm_word;
  logic [31:0]     col_inc;
  logic [3:0]      pad_prod;
  logic [1:0]      pad_calc;
  logic [2:0][7:0] res;
  logic [1:0]      res_n;
  logic            is_pix;

  // queue space is the only thing that holds the input
  assign in_ready  = !q_full;
  assign cfg_ready = 1'b1;
  assign take      = in_valid && in_ready;

  // classify the byte and work out the next file state
  always_comb begin
    pos_nxt    = pos_r;
    field_nxt  = field_r;
    offset_nxt = offset_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    chan_nxt   = chan_r;
    held_b_nxt = held_b_r;
    held_g_nxt = held_g_r;
    pad_nxt    = pad_r;
    err_nxt    = err_r;
    res        = '0;
    res_n      = 2'd0;
    is_pix     = 1'b0;

    asm_word = {in_data_byte, field_r[31:8]};
    col_inc  = col_r + 32'd1;
    pad_prod = 4'({2'b00, width_r[1:0]} * 4'd3);
    pad_calc = 2'(3'd4 - {1'b0, pad_prod[1:0]});

    if (!err_r && pos_r < HEADER_LEN) begin
      // header bytes: assemble little-endian fields and check them
      field_nxt = asm_word;
      if (pos_r == POS_SIG_END && asm_word[31:16] != BMP_SIGNATURE) err_nxt = 1'b1;
      if (pos_r == POS_OFFSET_END) offset_nxt = asm_word;
      if (pos_r == POS_DIB_END && asm_word != DIB_SIZE) err_nxt = 1'b1;
      if (pos_r == POS_WIDTH_END) width_nxt = asm_word;
      if (pos_r == POS_HEIGHT_END) height_nxt = asm_word;
      if (pos_r == POS_DEPTH_END && asm_word[31:16] != COLOUR_BITS) err_nxt = 1'b1;
      res[0] = in_data_byte;
      res_n  = 2'd1;
    end else if (!err_r && pos_r >= offset_r && width_r != 32'd0) begin
      if (pad_r != 2'd0) begin
        // row padding passes
        pad_nxt = pad_r - 2'd1;
        res[0]  = in_data_byte;
        res_n   = 2'd1;
      end else if (row_r < height_r) begin
        case (chan_r)
          CH_BLUE: begin
            held_b_nxt = in_data_byte;
            chan_nxt   = CH_GREEN;
          end
          CH_GREEN: begin
            held_g_nxt = in_data_byte;
            chan_nxt   = CH_RED;
          end
          default: begin
            // red byte completes the pixel
            is_pix   = 1'b1;
            res[0]   = held_b_r;
            res[1]   = held_g_r;
            res[2]   = in_data_byte;
            res_n    = 2'd3;
            chan_nxt = CH_BLUE;
            if (col_inc >= width_r) begin
              col_nxt = 32'd0;
              row_nxt = row_r + 32'd1;
              pad_nxt = pad_calc;
            end else begin
              col_nxt = col_inc;
            end
          end
        endcase
      end else begin
        res[0] = in_data_byte;
        res_n  = 2'd1;
      end
    end else begin
      res[0] = in_data_byte;
      res_n  = 2'd1;
    end

    // partial pixel at end of file goes out as it came
    if (in_last_byte && chan_nxt != CH_BLUE) begin
      res[res_n] = held_b_nxt;
      res_n      = res_n + 2'd1;
      if (chan_nxt == CH_RED) begin
        res[res_n] = held_g_nxt;
        res_n      = res_n + 2'd1;
      end
    end

    push_entry.op    = is_pix ? (mode_r ? OP_GRAY : OP_INVERT) : OP_PASS;
    push_entry.count = res_n;
    push_entry.slots = res;
    push_entry.err   = err_nxt;
    push_entry.last  = in_last_byte;
    push_valid       = take && (res_n != 2'd0);

    // saturating position
    if (pos_r != 32'hFFFF_FFFF) pos_nxt = pos_r + 32'd1;

    // end of file returns the parser to its idle state
    if (in_last_byte) begin
      pos_nxt    = 32'd0;
      field_nxt  = 32'd0;
      offset_nxt = 32'd0;
      width_nxt  = 32'd0;
      height_nxt = 32'd0;
      col_nxt    = 32'd0;
      row_nxt    = 32'd0;
      chan_nxt   = CH_BLUE;
      held_b_nxt = 8'd0;
      held_g_nxt = 8'd0;
      pad_nxt    = 2'd0;
      err_nxt    = 1'b0;
    end
  end

  // file state and mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      pos_r    <= 32'd0;
      field_r  <= 32'd0;
      offset_r <= 32'd0;
      width_r  <= 32'd0;
      height_r <= 32'd0;
      col_r    <= 32'd0;
      row_r    <= 32'd0;
      chan_r   <= CH_BLUE;
      held_b_r <= 8'd0;
      held_g_r <= 8'd0;
      pad_r    <= 2'd0;
      err_r    <= 1'b0;
    end else begin
      if (cfg_valid) mode_r <= cfg_mode;
      if (take) begin
        pos_r    <= pos_nxt;
        field_r  <= field_nxt;
        offset_r <= offset_nxt;
        width_r  <= width_nxt;
        height_r <= height_nxt;
        col_r    <= col_nxt;
        row_r    <= row_nxt;
        chan_r   <= chan_nxt;
        held_b_r <= held_b_nxt;
        held_g_r <= held_g_nxt;
        pad_r    <= pad_nxt;
        err_r    <= err_nxt;
      end
    end
  end

endmodule

>>> src/bpig_fifo.sv
// short entry queue between front and back end
module bpig_fifo
  import bpig_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push_valid,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   head_valid,
  output entry_t head
);

  entry_t                    mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr_r;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr_r;
  logic [QUEUE_PTR_BITS:0]   count_r;

  assign full       = (count_r == (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_valid) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push_valid && !pop) count_r <= count_r + 1'b1;
      else if (!push_valid && pop) count_r <= count_r - 1'b1;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push_valid) mem_r[wr_ptr_r] <= push_entry;
  end

endmodule

>>> src/bpig_back.sv
// back end: luma, gamma lookup and result byte sequencer
module bpig_back
  import bpig_pkg::*;
#(
  parameter int GAMMA_INDEX_BITS = 12,
  parameter int LUMA_FRAC_BITS   = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  entry_t     head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_format_error,
  output logic       out_file_end
);

  localparam int GAMMA_SIZE = 1 << GAMMA_INDEX_BITS;
  localparam int LUMA_W     = LUMA_FRAC_BITS + 10;
  localparam int LUMA_SHIFT = LUMA_FRAC_BITS + 8 - GAMMA_INDEX_BITS;

  localparam longint unsigned W_RED_L   = ((64'd2126 << LUMA_FRAC_BITS) + 64'd5000) / 64'd10000;
  localparam longint unsigned W_BLUE_L  = ((64'd722 << LUMA_FRAC_BITS) + 64'd5000) / 64'd10000;
  localparam longint unsigned W_GREEN_L = (64'd1 << LUMA_FRAC_BITS) - W_RED_L - W_BLUE_L;
  localparam longint unsigned GAMMA_DEN = 64'd255 << (GAMMA_INDEX_BITS - 8);

  // wide integer for the exact gamma comparison at elaboration
  typedef logic [319:0] big_t;

  function automatic big_t pow12(big_t x);
    big_t x2, x3, x6;
    x2 = x * x;
    x3 = x2 * x;
    x6 = x3 * x3;
    return x6 * x6;
  endfunction

  function automatic big_t pow5(big_t x);
    big_t x2, x4;
    x2 = x * x;
    x4 = x2 * x2;
    return x4 * x;
  endfunction

  localparam big_t GAMMA_K12 = pow12(big_t'(269025));
  localparam big_t DEN_P5    = pow5(big_t'(GAMMA_DEN));

  // true when v does not exceed 255 * srgb(i / den)
  function automatic logic gamma_reaches(longint unsigned v, longint unsigned i);
    logic hit;
    big_t lhs, rhs;
    if (i * 64'd10000000 <= 64'd31308 * GAMMA_DEN) begin
      hit = (64'd100 * GAMMA_DEN * v <= 64'd329460 * i);
    end else begin
      lhs = pow12(big_t'(64'd1000 * v + 64'd14025)) * DEN_P5;
      rhs = GAMMA_K12 * pow5(big_t'(i));
      hit = (lhs <= rhs);
    end
    return hit;
  endfunction

  // largest code reached, by binary search over the 8 bits
  function automatic logic [7:0] gamma_entry(longint unsigned i);
    logic [7:0] v;
    logic [7:0] cand;
    int         b;
    v = 8'd0;
    for (b = 7; b >= 0; b--) begin
      cand = v | (8'd1 << b);
      if (gamma_reaches(longint'(cand), i)) v = cand;
    end
    return v;
  endfunction

  // gamma table contents
  logic [7:0] gamma_rom [GAMMA_SIZE];

  for (genvar gi = 0; gi < GAMMA_SIZE; gi++) begin : g_gamma
    localparam logic [7:0] ENTRY = gamma_entry(longint'(gi));
    assign gamma_rom[gi] = ENTRY;
  end

  logic                        s1_v_r, s2_v_r;
  entry_t                      s1_e_r, s2_e_r;
  logic [GAMMA_INDEX_BITS-1:0] s1_idx_r;
  logic [7:0]                  rom_q_r;
  logic [1:0]                  k_r;
  logic                        out_valid_r;
  logic [7:0]                  out_byte_r;
  logic                        out_run_last_r, out_format_error_r, out_file_end_r;

  logic                        out_load, s2_last_slot, s2_done, s2_free, s1_move, s1_free;
  logic [LUMA_W-1:0]           luma;
  logic [GAMMA_INDEX_BITS-1:0] luma_idx;
  logic [7:0]                  slot_byte, slot_val;

  // stage handshakes
  always_comb begin
    out_load     = s2_v_r && (!out_valid_r || out_ready);
    s2_last_slot = (k_r == s2_e_r.count - 2'd1);
    s2_done      = out_load && s2_last_slot;
    s2_free      = !s2_v_r || s2_done;
    s1_move      = s1_v_r && s2_free;
    s1_free      = !s1_v_r || s1_move;
    pop          = head_valid && s1_free;
  end

  // luma of the queued pixel
  always_comb begin
    luma = LUMA_W'(W_RED_L) * LUMA_W'(head.slots[2])
         + LUMA_W'(W_GREEN_L) * LUMA_W'(head.slots[1])
         + LUMA_W'(W_BLUE_L) * LUMA_W'(head.slots[0]);
    luma_idx = luma[LUMA_SHIFT +: GAMMA_INDEX_BITS];
  end

  // result byte for the current slot
  always_comb begin
    slot_byte = s2_e_r.slots[k_r];
    case (s2_e_r.op)
      OP_GRAY:   slot_val = rom_q_r;
      OP_INVERT: slot_val = ~slot_byte;
      default:   slot_val = slot_byte;
    endcase
  end

  // stage valids, slot counter and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      k_r         <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_free) s1_v_r <= head_valid;
      if (s2_free) s2_v_r <= s1_v_r;
      if (s2_done) k_r <= 2'd0;
      else if (out_load) k_r <= k_r + 2'd1;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // payload of the stages, gamma read and output register
  always_ff @(posedge clk) begin
    if (pop) begin
      s1_e_r   <= head;
      s1_idx_r <= luma_idx;
    end
    if (s1_move) begin
      s2_e_r  <= s1_e_r;
      rom_q_r <= gamma_rom[s1_idx_r];
    end
    if (out_load) begin
      out_byte_r         <= slot_val;
      out_run_last_r     <= s2_last_slot;
      out_format_error_r <= s2_e_r.err;
      out_file_end_r     <= s2_e_r.last && s2_last_slot;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_run_last     = out_run_last_r;
  assign out_format_error = out_format_error_r;
  assign out_file_end     = out_file_end_r;

endmodule

>>> src/bmp24_pixel_invert_grayscale.sv
// top level of the 24-bit bmp pixel rewriter
//
// Bytes of a bmp file enter on the in_ channel in file order, in_last_byte on
// the final one. The rewritten file leaves on the out_ channel one byte per
// transfer; out_run_last marks the last byte caused by an input byte and
// out_file_end the final byte of the file. The B and G bytes of a pixel give
// nothing; its R byte gives the three rewritten bytes.
// cfg_mode picks invert (0) or srgb luma gray (1); write it between files.
// Throughput: one input byte per cycle sustained while out_ready stays high;
// a pixel's three results leave the output register one per transfer, while
// the next pixel's bytes enter. A four-entry queue between the header parser
// and the pixel back end absorbs the bursts. When the receiver stalls, the
// output holds, the queue fills and in_ready drops once it is full.
// Reset clears all file state and mode; the gamma table is constant.
module bmp24_pixel_invert_grayscale
  import bpig_pkg::*;
#(
  parameter int GAMMA_INDEX_BITS = 12,
  parameter int LUMA_FRAC_BITS   = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_format_error,
  output logic       out_file_end,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_mode
);

  logic   q_full, push_valid, pop, head_valid;
  entry_t push_entry, head;

  // header parser and classifier
  bpig_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_mode     (cfg_mode),
    .q_full       (q_full),
    .push_valid   (push_valid),
    .push_entry   (push_entry)
  );

  // entry queue
  bpig_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // pixel back end
  bpig_back #(
    .GAMMA_INDEX_BITS (GAMMA_INDEX_BITS),
    .LUMA_FRAC_BITS   (LUMA_FRAC_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (head_valid),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_run_last     (out_run_last),
    .out_format_error (out_format_error),
    .out_file_end     (out_file_end)
  );

endmodule

>>> src/bpig_checker.sv
// port-level checks of the bmp pixel rewriter and their binding
`include "bmp24_pixel_invert_grayscale_macros.svh"

module bpig_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_run_last,
  input logic       out_format_error,
  input logic       out_file_end
);

  logic [10:0] out_payload;
  logic        out_xfer;
  logic        err_mid;

  // result payload and transfer
  assign out_payload = {out_byte, out_run_last, out_format_error, out_file_end};
  assign out_xfer    = out_valid && out_ready;
  assign err_mid     = out_format_error && !out_file_end;

  // stalled result holds
  `BPIG_ASSERT_HOLD(a_out_hold, out_valid, out_ready, out_payload)

  // file end always closes a run
  `BPIG_ASSERT_NOW(a_end_closes_run, out_valid && out_file_end, out_run_last)

  // the bytes of one run leave without gaps
  `BPIG_ASSERT_NEXT(a_run_no_gap, out_xfer && !out_run_last, out_valid)

  // a rejected header stays rejected until the file ends
  `BPIG_ASSERT_NEXT(a_error_sticky, out_xfer && err_mid, !out_valid || out_format_error)

endmodule

bind bmp24_pixel_invert_grayscale bpig_checker u_bpig_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_byte         (out_byte),
  .out_run_last     (out_run_last),
  .out_format_error (out_format_error),
  .out_file_end     (out_file_end)
);

>>> bench/tb_top.sv
// testbench of the 24-bit bmp pixel rewriter: random bmp files, byte-exact prediction
`timescale 1ns / 1ps

module tb_top;
  import bpig_pkg::*;

  // luma weights over 2^16 and the shift down to a gamma table index
  localparam int unsigned W_RED      = 13933;
  localparam int unsigned W_GREEN    = 46871;
  localparam int unsigned W_BLUE     = 4732;
  localparam int unsigned LUMA_SHIFT = 12;
  localparam int unsigned LUT_MASK   = 4095;
  localparam int unsigned LUT_DEN    = 4080;

  typedef logic [319:0] wide_t;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       fmt_err;
    logic       file_end;
  } out_rec_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  typedef enum int {
    FILE_GOOD,
    FILE_BAD_SIG,
    FILE_BAD_DIB,
    FILE_BAD_DEPTH,
    FILE_SHORT,
    FILE_NOISE
  } file_kind_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_last_byte = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_run_last;
  logic       out_format_error;
  logic       out_file_end;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_mode = 1'b0;

  bmp24_pixel_invert_grayscale u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_run_last     (out_run_last),
    .out_format_error (out_format_error),
    .out_file_end     (out_file_end),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_mode         (cfg_mode)
  );

  always #5 clk = ~clk;

  // bench bookkeeping
  byte_item_t pending_bytes[$];
  out_rec_t   expected_bytes[$];
  logic [7:0] file_buf[$];
  int         bytes_pushed = 0;
  int         bytes_accepted = 0;
  int         mismatches = 0;
  bit         idle_on = 1'b1;
  bit         rx_hold = 1'b0;
  bit         in_fire = 1'b0;
  int         in_gap = 0;
  int         out_gap = 0;

  // predictor state
  logic [7:0]  gamma_lut [0:4095];
  logic        mode_q = 1'b0;
  logic [31:0] pos_q = '0;
  logic [31:0] field_q = '0;
  logic [31:0] pix_off_q = '0;
  logic [31:0] img_w_q = '0;
  logic [31:0] img_h_q = '0;
  logic [31:0] col_q = '0;
  logic [31:0] row_q = '0;
  logic [1:0]  chan_q = '0;
  logic [7:0]  held_b_q = '0;
  logic [7:0]  held_g_q = '0;
  logic [1:0]  pad_q = '0;
  logic        err_q = 1'b0;

  function automatic wide_t wide_pow(input wide_t base, input int unsigned m, input int n);
    wide_t acc;
    acc = base;
    for (int k = 0; k < n; k++) acc = acc * wide_t'(m);
    return acc;
  endfunction

  // true when v does not exceed 255 * srgb(i / LUT_DEN), exact
  function automatic bit srgb_fits(input int unsigned v, input int unsigned i);
    longint unsigned li, lv;
    wide_t lhs, rhs;
    li = i;
    lv = v;
    if (li * 64'd10000000 <= 64'd31308 * LUT_DEN)
      return (64'd100 * LUT_DEN * lv) <= (64'd329460 * li);
    lhs = wide_pow(wide_pow(wide_t'(1), 1000 * v + 14025, 12), LUT_DEN, 5);
    rhs = wide_pow(wide_pow(wide_t'(1), 269025, 12), i, 5);
    return lhs <= rhs;
  endfunction

  function automatic void build_gamma_lut();
    int unsigned v;
    v = 0;
    for (int unsigned i = 0; i <= LUT_MASK; i++) begin
      while (v < 255 && srgb_fits(v + 1, i)) v++;
      gamma_lut[i] = v[7:0];
    end
  endfunction

  // rewrite one accepted file byte, queue the bytes it gives
  function automatic void rewrite_byte(input logic [7:0] b, input logic last);
    logic [7:0]  res [3];
    logic [7:0]  g;
    logic [31:0] p;
    int unsigned luma;
    int          n;
    out_rec_t    rec;
    p = pos_q;
    n = 0;
    if (!err_q && p < HEADER_LEN) begin
      // header field parse
      field_q = (field_q >> 8) | {b, 24'h0};
      if (p == POS_SIG_END && field_q[31:16] != BMP_SIGNATURE) err_q = 1'b1;
      if (p == POS_OFFSET_END) pix_off_q = field_q;
      if (p == POS_DIB_END && field_q != DIB_SIZE) err_q = 1'b1;
      if (p == POS_WIDTH_END) img_w_q = field_q;
      if (p == POS_HEIGHT_END) img_h_q = field_q;
      if (p == POS_DEPTH_END && field_q[31:16] != COLOUR_BITS) err_q = 1'b1;
      res[n] = b;
      n++;
    end else if (!err_q && p >= pix_off_q && img_w_q != 0) begin
      if (pad_q > 0) begin
        pad_q = pad_q - 2'd1;
        res[n] = b;
        n++;
      end else if (row_q < img_h_q) begin
        if (chan_q == 2'd0) begin
          held_b_q = b;
          chan_q = 2'd1;
        end else if (chan_q == 2'd1) begin
          held_g_q = b;
          chan_q = 2'd2;
        end else begin
          if (mode_q) begin
            luma = W_RED * b + W_GREEN * held_g_q + W_BLUE * held_b_q;
            g = gamma_lut[(luma >> LUMA_SHIFT) & LUT_MASK];
            res[0] = g;
            res[1] = g;
            res[2] = g;
          end else begin
            res[0] = 8'd255 - held_b_q;
            res[1] = 8'd255 - held_g_q;
            res[2] = 8'd255 - b;
          end
          n = 3;
          chan_q = 2'd0;
          col_q++;
          if (col_q >= img_w_q) begin
            col_q = 0;
            row_q++;
            pad_q = 2'(4 - (((img_w_q & 3) * 3) & 3));
          end
        end
      end else begin
        res[n] = b;
        n++;
      end
    end else begin
      res[n] = b;
      n++;
    end
    // partial pixel at end of file
    if (last && chan_q != 2'd0) begin
      res[n] = held_b_q;
      n++;
      if (chan_q == 2'd2) begin
        res[n] = held_g_q;
        n++;
      end
    end
    for (int k = 0; k < n; k++) begin
      rec.data     = res[k];
      rec.run_last = (k == n - 1);
      rec.fmt_err  = err_q;
      rec.file_end = last && (k == n - 1);
      expected_bytes.push_back(rec);
    end
    if (pos_q != 32'hFFFF_FFFF) pos_q++;
    if (last) begin
      pos_q = '0; field_q = '0; pix_off_q = '0; img_w_q = '0; img_h_q = '0;
      col_q = '0; row_q = '0; chan_q = '0; held_b_q = '0; held_g_q = '0;
      pad_q = '0; err_q = 1'b0;
    end
  endfunction

  // input side: note each transfer and predict it
  always @(posedge clk) begin
    in_fire <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      rewrite_byte(in_data_byte, in_last_byte);
      bytes_accepted++;
    end
  end

  // driver: next byte or an idle burst once the bus is free
  always @(negedge clk) begin
    byte_item_t it;
    if (!in_valid || in_fire) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_bytes.size() > 0 && idle_on && $urandom_range(0, 7) == 0) begin
        in_gap <= $urandom_range(0, 15);
        in_valid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        it = pending_bytes.pop_front();
        in_valid <= 1'b1;
        in_data_byte <= it.data;
        in_last_byte <= it.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    if (rx_hold) begin
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_gap <= $urandom_range(0, 15);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor: each result transfer against the oldest expected byte
  // fields shown as byte/run_last/format_error/file_end
  always @(posedge clk) begin
    out_rec_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_byte, out_run_last, out_format_error, out_file_end};
      if (expected_bytes.size() == 0) begin
        mismatches++;
        $display("%0t: expected none, actual %02h/%0b/%0b/%0b",
                 $time, got.data, got.run_last, got.fmt_err, got.file_end);
      end else begin
        want = expected_bytes.pop_front();
        if (got !== want) begin
          mismatches++;
          $display("%0t: expected %02h/%0b/%0b/%0b, actual %02h/%0b/%0b/%0b",
                   $time, want.data, want.run_last, want.fmt_err, want.file_end,
                   got.data, got.run_last, got.fmt_err, got.file_end);
        end
      end
    end
  end

  // one long receiver hold-off while a file is still being offered
  initial begin : rx_holdoff
    @(posedge clk);
    while (!(bytes_accepted >= 40 && pending_bytes.size() >= 12)) @(posedge clk);
    rx_hold = 1'b1;
    repeat (120) @(posedge clk);
    rx_hold = 1'b0;
  end

  initial begin : watchdog
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic logic [7:0] rnd_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void put_word(input logic [31:0] v, input int nbytes);
    for (int k = 0; k < nbytes; k++) file_buf.push_back(v[8*k +: 8]);
  endfunction

  // queue the first len bytes of the file buffer, last flag on the final one
  task automatic push_file(input int len);
    byte_item_t it;
    for (int k = 0; k < len; k++) begin
      it.data = file_buf[k];
      it.last = (k == len - 1);
      pending_bytes.push_back(it);
    end
    bytes_pushed += len;
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (bytes_accepted != bytes_pushed || expected_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_mode(input logic v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_mode <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    mode_q = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // build one bmp file of the given kind into the buffer; returns bytes sent
  task automatic gen_file(input file_kind_t kind, output int len);
    logic [31:0] off, w, h, dib;
    logic [15:0] sig, depth;
    int          body, gap, pad;
    file_buf.delete();
    if (kind == FILE_NOISE) begin
      len = $urandom_range(1, 12);
      for (int k = 0; k < len; k++) file_buf.push_back(rnd_byte());
      push_file(len);
      return;
    end
    w = $urandom_range(0, 4);
    if ($urandom_range(0, 9) == 0) w = $urandom;
    h = $urandom_range(0, 3);
    if ($urandom_range(0, 9) == 0) h = $urandom;
    off = HEADER_LEN + $urandom_range(0, 3);
    case ($urandom_range(0, 9))
      0: off = $urandom_range(0, 53);
      1: off = $urandom;
      default: ;
    endcase
    sig = BMP_SIGNATURE;
    if (kind == FILE_BAD_SIG) sig = sig ^ (16'h1 << $urandom_range(0, 15));
    dib = DIB_SIZE;
    if (kind == FILE_BAD_DIB) dib = dib ^ (32'h1 << $urandom_range(0, 31));
    depth = COLOUR_BITS;
    if (kind == FILE_BAD_DEPTH) depth = depth ^ (16'h1 << $urandom_range(0, 15));
    // 54-byte header
    put_word(32'(sig), 2);
    put_word($urandom, 4);
    put_word($urandom, 4);
    put_word(off, 4);
    put_word(dib, 4);
    put_word(w, 4);
    put_word(h, 4);
    put_word($urandom, 2);
    put_word(32'(depth), 2);
    for (int k = 0; k < 24; k++) file_buf.push_back(rnd_byte());
    // gap up to the pixels, rows with padding, then a tail
    gap = (off > HEADER_LEN && off <= HEADER_LEN + 3) ? int'(off - HEADER_LEN) : 0;
    pad = (4 - ((int'(w & 3) * 3) & 3)) & 3;
    if (w <= 4 && h <= 3) body = int'(h) * (int'(w) * 3 + pad);
    else body = $urandom_range(0, 24);
    body += gap + $urandom_range(0, 3);
    for (int k = 0; k < body; k++) file_buf.push_back(rnd_byte());
    len = file_buf.size();
    if (kind == FILE_SHORT) len = $urandom_range(1, 53);
    else if (kind == FILE_GOOD && len > 55 && $urandom_range(0, 3) == 0)
      len = $urandom_range(55, len);
    push_file(len);
  endtask

  initial begin : stimulus
    int         rand_bytes, len, f, r;
    file_kind_t kind;
    build_gamma_lut();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    write_mode(1'b1);

    // single-byte files, both extremes
    file_buf.delete(); file_buf.push_back(8'h00); push_file(1);
    file_buf.delete(); file_buf.push_back(8'hFF); push_file(1);
    // signature wrong in its second byte, then in its first
    file_buf.delete(); put_word(32'h55AA_4E42, 4); push_file(4);
    file_buf.delete(); put_word(32'h0012_4D43, 3); push_file(3);
    // file ending inside the header, before any check fails
    file_buf.delete(); put_word(32'h0180_4D42, 4); push_file(4);
    file_buf.delete(); put_word(32'h0000_0042, 1); push_file(1);

    // random files, mostly well formed
    rand_bytes = 0;
    f = 0;
    while (rand_bytes < 330) begin
      if (rand_bytes >= 250) idle_on = 1'b0;
      if (f < 2 || $urandom_range(0, 2) == 0) begin
        wait_idle();
        write_mode(f == 0 ? 1'b1 : f == 1 ? 1'b0 : 1'($urandom_range(0, 1)));
      end
      r = $urandom_range(0, 9);
      if (f < 2 || r <= 5) kind = FILE_GOOD;
      else if (r == 6) kind = FILE_BAD_SIG;
      else if (r == 7) kind = FILE_BAD_DIB;
      else if (r == 8) kind = FILE_BAD_DEPTH;
      else kind = $urandom_range(0, 1) ? FILE_SHORT : FILE_NOISE;
      gen_file(kind, len);
      rand_bytes += len;
      f++;
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
